[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion wrappers for the ARQ sender core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SWARQ_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define SWARQ_ASSERT(lbl, prop, msg) \
  `SWARQ_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/swarq_pkg.sv]
// ----------------------------------------------------------------------------
// swarq_pkg
// Types, codes and constants of the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

  // default sizes
  localparam int MAX_FRAMES_DEF = 32;
  localparam int MAX_WINDOW_DEF = 8;
  localparam int TIME_BITS_DEF  = 16;

  // register widths and reset values
  localparam int TOTAL_W     = 6;
  localparam int WIN_W       = 4;
  localparam int TIMEOUT_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [TOTAL_W-1:0]   TOTAL_RST   = 6'd20;
  localparam logic [WIN_W-1:0]     WIN_RST     = 4'd4;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd700;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // field widths
  localparam int OP_W  = 2;
  localparam int SEQ_W = 5;

  // event opcodes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ACK,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic             frame_valid;
    logic [SEQ_W-1:0] frame_seq;
    logic             is_retransmit;
    logic             all_acked;
    logic             last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [SEQ_W-1:0] ack_seq;
  } cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   frame_cnt;
    logic [WIN_W-1:0]     window_size;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

[rtl/core/swarq_fifo.sv]
// ----------------------------------------------------------------------------
// swarq_fifo
// Small register-based request queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module swarq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/swarq_front.sv]
// ----------------------------------------------------------------------------
// swarq_front
// Accepts input events and classifies them into commands for the sequencer.
// ----------------------------------------------------------------------------
module swarq_front (
  input  logic                 push_i,
  input  swarq_pkg::in_item_t  item_i,
  output logic                 full_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output swarq_pkg::cmd_t      q_cmd_o
);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // opcode decode, unused code becomes a status-only command
  always_comb begin
    q_cmd_o.ack_seq = item_i.ack_seq;
    case (item_i.opcode)
      swarq_pkg::OP_START: q_cmd_o.kind = swarq_pkg::CMD_START;
      swarq_pkg::OP_ACK:   q_cmd_o.kind = swarq_pkg::CMD_ACK;
      swarq_pkg::OP_TICK:  q_cmd_o.kind = swarq_pkg::CMD_TICK;
      default:             q_cmd_o.kind = swarq_pkg::CMD_NOP;
    endcase
  end

endmodule

[rtl/core/swarq_back.sv]
// ----------------------------------------------------------------------------
// swarq_back
// Window sequencer: slides the base, scans timers, resends and fills frames.
// ----------------------------------------------------------------------------
module swarq_back #(
  parameter int MAX_FRAMES = swarq_pkg::MAX_FRAMES_DEF,
  parameter int MAX_WINDOW = swarq_pkg::MAX_WINDOW_DEF,
  parameter int TIME_BITS  = swarq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swarq_pkg::cfg_t      cfg_i,
  input  logic                 cmd_empty_i,
  input  swarq_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output swarq_pkg::out_item_t out_item_o
);

  localparam int IDXW = $clog2(MAX_FRAMES);
  localparam int SEQW = $clog2(MAX_FRAMES + 1);
  localparam int WW   = $clog2(MAX_WINDOW + 1);
  localparam int TW   = (SEQW > swarq_pkg::TOTAL_W) ? SEQW : swarq_pkg::TOTAL_W;
  localparam int VW   = (WW > swarq_pkg::WIN_W) ? WW : swarq_pkg::WIN_W;
  localparam int LW   = ((SEQW > WW) ? SEQW : WW) + 1;
  localparam int AW   = (SEQW > swarq_pkg::SEQ_W) ? SEQW : swarq_pkg::SEQ_W;
  localparam int CMPW = (TIME_BITS > swarq_pkg::TIMEOUT_W) ? TIME_BITS
                                                           : swarq_pkg::TIMEOUT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SLIDE = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RETX  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [SEQW-1:0]             base_q, base_d, next_q, next_d, idx_q, idx_d;
  logic [MAX_FRAMES-1:0]       acked_q, acked_d;
  logic [TIME_BITS-1:0]        tick_q, tick_d;
  logic                        run_q, run_d;
  logic                        lost_q, lost_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [IDXW-1:0]             rd_idx_q;
  logic [TIME_BITS-1:0]        rd_data_q;
  logic                        pend_vld_q, pend_vld_d;
  logic [swarq_pkg::SEQ_W-1:0] pend_seq_q, pend_seq_d;
  logic                        pend_retx_q, pend_retx_d;

  logic [TIME_BITS-1:0]        send_time_mem [MAX_FRAMES];

  logic [TW-1:0]               tot_x;
  logic [VW-1:0]               win_x;
  logic [SEQW-1:0]             eff_tot;
  logic [WW-1:0]               eff_win;
  logic [LW-1:0]               lim;
  logic                        fill_go, done, emit_ok;
  logic [AW-1:0]               ack_x;
  logic [IDXW-1:0]             ack_idx;
  logic [TIME_BITS-1:0]        age;
  logic                        rd_en;
  logic                        emit_req, emit_retx;
  logic [SEQW-1:0]             emit_frame;

  // saturated register values and window bounds
  always_comb begin
    tot_x = TW'(cfg_i.frame_cnt);
    if (tot_x == '0) begin
      eff_tot = SEQW'(1);
    end else if (tot_x > TW'(MAX_FRAMES)) begin
      eff_tot = SEQW'(MAX_FRAMES);
    end else begin
      eff_tot = SEQW'(tot_x);
    end
    win_x = VW'(cfg_i.window_size);
    if (win_x == '0) begin
      eff_win = WW'(1);
    end else if (win_x > VW'(MAX_WINDOW)) begin
      eff_win = WW'(MAX_WINDOW);
    end else begin
      eff_win = WW'(win_x);
    end
  end

  assign lim     = LW'(base_q) + LW'(eff_win);
  assign fill_go = run_q && (LW'(next_q) < lim) && (next_q < eff_tot);
  assign done    = (base_q >= eff_tot);
  assign emit_ok = !pend_vld_q || !out_full_i;
  assign ack_x   = AW'(cmd_i.ack_seq);
  assign ack_idx = IDXW'(cmd_i.ack_seq);
  assign age     = tick_q - rd_data_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    idx_d       = idx_q;
    acked_d     = acked_q;
    tick_d      = tick_q;
    run_d       = run_q;
    lost_d      = lost_q;
    rd_vld_d    = 1'b0;
    rd_en       = 1'b0;
    pend_vld_d  = pend_vld_q;
    pend_seq_d  = pend_seq_q;
    pend_retx_d = pend_retx_q;
    cmd_pop_o   = 1'b0;
    out_push_o  = 1'b0;
    out_item_o  = '0;
    emit_req    = 1'b0;
    emit_retx   = 1'b0;
    emit_frame  = next_q;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            swarq_pkg::CMD_START: begin
              base_d  = '0;
              next_d  = '0;
              acked_d = '0;
              run_d   = 1'b1;
              state_d = ST_FILL;
            end
            swarq_pkg::CMD_ACK: begin
              if (run_q && (ack_x < AW'(next_q)) && (ack_x < AW'(MAX_FRAMES)) &&
                  !acked_q[ack_idx]) begin
                acked_d[ack_idx] = 1'b1;
                state_d          = ST_SLIDE;
              end else begin
                state_d = ST_FILL;
              end
            end
            swarq_pkg::CMD_TICK: begin
              tick_d = tick_q + TIME_BITS'(1);
              if (run_q) begin
                idx_d   = base_q;
                lost_d  = 1'b0;
                state_d = ST_SCAN;
              end else begin
                state_d = ST_FILL;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // slide the base one acknowledged frame a cycle
      ST_SLIDE: begin
        if ((base_q < eff_tot) && acked_q[base_q[IDXW-1:0]]) begin
          base_d = base_q + SEQW'(1);
        end else begin
          if (done) begin
            run_d = 1'b0;
          end
          state_d = ST_FILL;
        end
      end

      // read send times one a cycle, compare each in the cycle after its read
      ST_SCAN: begin
        if (idx_q < next_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + SEQW'(1);
        end
        if (rd_vld_q && !acked_q[rd_idx_q] &&
            (CMPW'(age) > CMPW'(cfg_i.timeout_ticks))) begin
          lost_d = 1'b1;
        end
        if (!(idx_q < next_q) && !rd_vld_q) begin
          idx_d   = base_q;
          state_d = lost_q ? ST_RETX : ST_FILL;
        end
      end

      // resend every unacknowledged frame of the window
      ST_RETX: begin
        if (idx_q < next_q) begin
          if (acked_q[idx_q[IDXW-1:0]]) begin
            idx_d = idx_q + SEQW'(1);
          end else if (emit_ok) begin
            emit_req   = 1'b1;
            emit_retx  = 1'b1;
            emit_frame = idx_q;
            idx_d      = idx_q + SEQW'(1);
          end
        end else begin
          state_d = ST_FILL;
        end
      end

      // issue new frames until the window is full or every frame has been sent
      ST_FILL: begin
        if (fill_go) begin
          if (emit_ok) begin
            emit_req   = 1'b1;
            emit_frame = next_q;
            next_d     = next_q + SEQW'(1);
          end
        end else begin
          state_d = ST_DONE;
        end
      end

      // final result of the event, status-only when nothing was sent
      ST_DONE: begin
        if (!out_full_i) begin
          out_push_o               = 1'b1;
          out_item_o.frame_valid   = pend_vld_q;
          out_item_o.frame_seq     = pend_vld_q ? pend_seq_q : '0;
          out_item_o.is_retransmit = pend_vld_q && pend_retx_q;
          out_item_o.all_acked     = done;
          out_item_o.last          = 1'b1;
          pend_vld_d               = 1'b0;
          state_d                  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // hold the newest send until the next one shows it was not the last
    if (emit_req) begin
      if (pend_vld_q) begin
        out_push_o               = 1'b1;
        out_item_o.frame_valid   = 1'b1;
        out_item_o.frame_seq     = pend_seq_q;
        out_item_o.is_retransmit = pend_retx_q;
        out_item_o.all_acked     = done;
        out_item_o.last          = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_seq_d  = swarq_pkg::SEQ_W'(emit_frame);
      pend_retx_d = emit_retx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      next_q     <= '0;
      idx_q      <= '0;
      acked_q    <= '0;
      tick_q     <= '0;
      run_q      <= 1'b0;
      lost_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      next_q     <= next_d;
      idx_q      <= idx_d;
      acked_q    <= acked_d;
      tick_q     <= tick_d;
      run_q      <= run_d;
      lost_q     <= lost_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // payload of the pending send
  always_ff @(posedge clk_i) begin
    pend_seq_q  <= pend_seq_d;
    pend_retx_q <= pend_retx_d;
  end

  // send time memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (emit_req) begin
      send_time_mem[emit_frame[IDXW-1:0]] <= tick_q;
    end
    if (rd_en) begin
      rd_data_q <= send_time_mem[idx_q[IDXW-1:0]];
      rd_idx_q  <= idx_q[IDXW-1:0];
    end
  end

endmodule

[rtl/core/sliding_window_arq_sender.sv]
// ----------------------------------------------------------------------------
// sliding_window_arq_sender
// Selective-repeat ARQ sender turning start, ack and tick events into sends.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// events    in         push / full          in_item_i  (opcode, ack_seq)
// sends     out        pop / empty          out_item_o (frame_valid .. last)
// config    in         cfg_we_i, no wait    cfg_idx_i, cfg_data_i
//
// The sequencer pops each event, fills new frames, and ends with a final
// result (only that for the unused opcode); a taken ack first slides the
// base over acknowledged frames, and a running tick first scans the timers
// of outstanding frames and, on a timeout, resends the unacknowledged ones.
// Reset clears control state at once, with no clearing pass; a full result
// queue stalls the sequencer and full rises once two requests wait.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_arq_sender #(
  parameter int MAX_FRAMES = swarq_pkg::MAX_FRAMES_DEF,
  parameter int MAX_WINDOW = swarq_pkg::MAX_WINDOW_DEF,
  parameter int TIME_BITS  = swarq_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  swarq_pkg::in_item_t                 in_item_i,
  output logic                                full,
  input  logic                                pop,
  output swarq_pkg::out_item_t                out_item_o,
  output logic                                empty,
  input  logic                                cfg_we_i,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  swarq_pkg::cfg_t      cfg_q;
  logic                 c_push, c_full, c_empty, c_pop;
  swarq_pkg::cmd_t      c_wcmd, c_rcmd;
  logic                 o_push, o_full;
  swarq_pkg::out_item_t o_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_cnt     <= swarq_pkg::TOTAL_RST;
      cfg_q.window_size   <= swarq_pkg::WIN_RST;
      cfg_q.timeout_ticks <= swarq_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swarq_pkg::REG_TOTAL:   cfg_q.frame_cnt     <= cfg_data_i[swarq_pkg::TOTAL_W-1:0];
        swarq_pkg::REG_WINDOW:  cfg_q.window_size   <= cfg_data_i[swarq_pkg::WIN_W-1:0];
        swarq_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i[swarq_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // event intake and decode
  swarq_front u_front (
    .push_i   (push),
    .item_i   (in_item_i),
    .full_o   (full),
    .q_full_i (c_full),
    .q_push_o (c_push),
    .q_cmd_o  (c_wcmd)
  );

  // command queue between intake and sequencer
  swarq_fifo #(
    .WIDTH ($bits(swarq_pkg::cmd_t)),
    .DEPTH (swarq_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (c_push),
    .wdata_i (c_wcmd),
    .full_o  (c_full),
    .pop_i   (c_pop),
    .rdata_o (c_rcmd),
    .empty_o (c_empty)
  );

  // window sequencer
  swarq_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_WINDOW (MAX_WINDOW),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (c_empty),
    .cmd_i       (c_rcmd),
    .cmd_pop_o   (c_pop),
    .out_full_i  (o_full),
    .out_push_o  (o_push),
    .out_item_o  (o_item)
  );

  // result queue
  swarq_fifo #(
    .WIDTH ($bits(swarq_pkg::out_item_t)),
    .DEPTH (swarq_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .wdata_i (o_item),
    .full_o  (o_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

  // sequencer never pushes into a full result queue
  `SWARQ_ASSERT(a_out_no_overflow, !(o_push && o_full), "result pushed while queue full")
  // intake never pushes into a full command queue
  `SWARQ_ASSERT(a_cmd_no_overflow, !(c_push && c_full), "command pushed while queue full")
  // a status-only result is always the single, final one of its event
  `SWARQ_ASSERT(a_status_last,
                o_push |-> (o_item.frame_valid || (o_item.last && !o_item.is_retransmit)),
                "status result not final")
  // the final result of an event is followed by a cycle without results
  `SWARQ_ASSERT(a_last_gap, (o_push && o_item.last) |=> !o_push, "result right after final result")

endmodule
